/* src/pva_pkg.sv */
package pva_pkg;

  localparam int CORDIC_STAGES = 16;

  localparam int XW        = 36;   // x/y datapath, Q.14 plus growth
  localparam int ZW        = 30;   // angle datapath, 2^-24 rad
  localparam int KW        = 31;   // gain, Q1.30
  localparam int ANG_SHIFT = 11;
  localparam int XY_SHIFT  = 14;
  localparam int AQW       = ZW - ANG_SHIFT;

  localparam logic signed [ZW-1:0] PI_FIX      = 30'sd52707179;
  localparam logic signed [ZW-1:0] HALF_PI_FIX = 30'sd26353589;
  localparam logic signed [AQW-1:0] PI_Q13     = 19'sd25736;
  localparam logic [22:0]           MAG_MAX    = 23'd131071;

  typedef logic signed [XW-1:0] xy_t;
  typedef logic signed [ZW-1:0] ang_t;

  typedef struct packed {
    xy_t  x;
    xy_t  y;
    ang_t z;
  } rot_t;

  // result that skips the CORDIC path
  typedef struct packed {
    logic        byp;
    logic [16:0] mag;
    logic [15:0] dir;
  } side_t;

  function automatic ang_t atan_val(input int i);
    ang_t v;
    case (i)
      0:  v = 30'sd13176795;
      1:  v = 30'sd7778716;
      2:  v = 30'sd4110060;
      3:  v = 30'sd2086331;
      4:  v = 30'sd1047214;
      5:  v = 30'sd524117;
      6:  v = 30'sd262123;
      7:  v = 30'sd131069;
      8:  v = 30'sd65536;
      9:  v = 30'sd32768;
      10: v = 30'sd16384;
      11: v = 30'sd8192;
      12: v = 30'sd4096;
      13: v = 30'sd2048;
      14: v = 30'sd1024;
      15: v = 30'sd512;
      16: v = 30'sd256;
      17: v = 30'sd128;
      18: v = 30'sd64;
      19: v = 30'sd32;
      20: v = 30'sd16;
      21: v = 30'sd8;
      22: v = 30'sd4;
      23: v = 30'sd2;
      24: v = 30'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // k -= floor(k / (4^i + 1)) per stage, quotient by shift-subtract
  function automatic logic [KW-1:0] gain_k();
    logic [63:0] k;
    logic [63:0] d;
    logic [63:0] q;
    logic [63:0] r;
    k = 64'd1 << 30;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      d = (64'd1 << (2 * i)) + 64'd1;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
        r = {r[62:0], k[b]};
        if (r >= d) begin
          r    = r - d;
          q[b] = 1'b1;
        end
      end
      k = k - q;
    end
    return k[KW-1:0];
  endfunction

  localparam logic [KW-1:0] GAIN_K = gain_k();

  function automatic rot_t rot_step(input rot_t s, input int i);
    rot_t o;
    if (s.z >= 0) begin
      o.x = s.x - (s.y >>> i);
      o.y = s.y + (s.x >>> i);
      o.z = s.z - atan_val(i);
    end else begin
      o.x = s.x + (s.y >>> i);
      o.y = s.y - (s.x >>> i);
      o.z = s.z + atan_val(i);
    end
    return o;
  endfunction

  function automatic rot_t vec_step(input rot_t s, input int i);
    rot_t o;
    if (s.y >= 0) begin
      o.x = s.x + (s.y >>> i);
      o.y = s.y - (s.x >>> i);
      o.z = s.z + atan_val(i);
    end else begin
      o.x = s.x - (s.y >>> i);
      o.y = s.y + (s.x >>> i);
      o.z = s.z - atan_val(i);
    end
    return o;
  endfunction

endpackage

/* src/pva_in_if.sv */
interface pva_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] a_magnitude;
  logic signed [15:0] a_direction;
  logic [15:0] b_magnitude;
  logic signed [15:0] b_direction;

  modport source (output valid, a_magnitude, a_direction, b_magnitude, b_direction,
                  input ready);
  modport sink   (input valid, a_magnitude, a_direction, b_magnitude, b_direction,
                  output ready);
endinterface

/* src/pva_out_if.sv */
interface pva_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] sum_magnitude;
  logic signed [15:0] sum_direction;

  modport source (output valid, sum_magnitude, sum_direction, input ready);
  modport sink   (input valid, sum_magnitude, sum_direction, output ready);
endinterface

/* src/pva_rotate.sv */
module pva_rotate (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  logic [15:0]         a_mag,
  input  logic signed [15:0]  a_dir,
  input  logic [15:0]         b_mag,
  input  logic signed [15:0]  b_dir,
  output logic                dn_valid,
  input  logic                dn_ready,
  output pva_pkg::rot_t       dn_a,
  output pva_pkg::rot_t       dn_b,
  output pva_pkg::side_t      dn_side
);

  localparam int N = pva_pkg::CORDIC_STAGES;
  localparam int D = N + 1;

  logic [D-1:0]   v_r;
  logic [D:0]     rdy;
  pva_pkg::rot_t  a_r    [0:N];
  pva_pkg::rot_t  b_r    [0:N];
  pva_pkg::side_t side_r [0:N];
  pva_pkg::rot_t  a_nxt;
  pva_pkg::rot_t  b_nxt;
  pva_pkg::side_t side_nxt;

  // stage moves when empty or when the next one moves
  always_comb begin
    rdy[D] = dn_ready;
    for (int d = D - 1; d >= 0; d--) begin
      rdy[d] = !v_r[d] || rdy[d+1];
    end
  end

  function automatic pva_pkg::rot_t fold(input logic [15:0] m, input logic signed [15:0] a);
    pva_pkg::rot_t  o;
    pva_pkg::xy_t   x0;
    pva_pkg::ang_t  z0;
    x0 = pva_pkg::xy_t'({m, {pva_pkg::XY_SHIFT{1'b0}}});
    z0 = pva_pkg::ang_t'(a) <<< pva_pkg::ANG_SHIFT;
    o.y = '0;
    if (z0 > pva_pkg::HALF_PI_FIX) begin
      o.z = z0 - pva_pkg::PI_FIX;
      o.x = -x0;
    end else if (z0 < -pva_pkg::HALF_PI_FIX) begin
      o.z = z0 + pva_pkg::PI_FIX;
      o.x = -x0;
    end else begin
      o.z = z0;
      o.x = x0;
    end
    return o;
  endfunction

  always_comb begin
    a_nxt = fold(a_mag, a_dir);
    b_nxt = fold(b_mag, b_dir);
    side_nxt = '0;
    if (a_mag == '0 && b_mag == '0) begin
      side_nxt.byp = 1'b1;
    end else if (a_mag == '0) begin
      side_nxt.byp = 1'b1;
      side_nxt.mag = {1'b0, b_mag};
      side_nxt.dir = b_dir;
    end else if (b_mag == '0) begin
      side_nxt.byp = 1'b1;
      side_nxt.mag = {1'b0, a_mag};
      side_nxt.dir = a_dir;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int d = 0; d < D; d++) begin
        if (rdy[d]) begin
          v_r[d] <= (d == 0) ? up_valid : v_r[d-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      a_r[0]    <= a_nxt;
      b_r[0]    <= b_nxt;
      side_r[0] <= side_nxt;
    end
    for (int i = 0; i < N; i++) begin
      if (rdy[i+1]) begin
        a_r[i+1]    <= pva_pkg::rot_step(a_r[i], i);
        b_r[i+1]    <= pva_pkg::rot_step(b_r[i], i);
        side_r[i+1] <= side_r[i];
      end
    end
  end

  assign up_ready = rdy[0];
  assign dn_valid = v_r[D-1];
  assign dn_a     = a_r[N];
  assign dn_b     = b_r[N];
  assign dn_side  = side_r[N];

endmodule

/* src/pva_vector.sv */
module pva_vector (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  pva_pkg::rot_t  up_a,
  input  pva_pkg::rot_t  up_b,
  input  pva_pkg::side_t up_side,
  output logic           dn_valid,
  input  logic           dn_ready,
  output pva_pkg::rot_t  dn_v,
  output pva_pkg::side_t dn_side
);

  localparam int N = pva_pkg::CORDIC_STAGES;
  localparam int D = N + 2;

  logic [D-1:0]   v_r;
  logic [D:0]     rdy;
  pva_pkg::rot_t  s_r    [0:D-1];
  pva_pkg::side_t side_r [0:D-1];
  pva_pkg::rot_t  sum_nxt;
  pva_pkg::rot_t  prep_nxt;
  pva_pkg::side_t prep_side_nxt;

  always_comb begin
    rdy[D] = dn_ready;
    for (int d = D - 1; d >= 0; d--) begin
      rdy[d] = !v_r[d] || rdy[d+1];
    end
  end

  always_comb begin
    sum_nxt.x = up_a.x + up_b.x;
    sum_nxt.y = up_a.y + up_b.y;
    sum_nxt.z = '0;
  end

  // fold the left half plane onto the right, start at plus or minus pi
  always_comb begin
    prep_nxt      = s_r[0];
    prep_side_nxt = side_r[0];
    if (s_r[0].x < 0) begin
      prep_nxt.x = -s_r[0].x;
      prep_nxt.y = -s_r[0].y;
      prep_nxt.z = (s_r[0].y >= 0) ? pva_pkg::PI_FIX : -pva_pkg::PI_FIX;
    end
    if (!side_r[0].byp && s_r[0].x == '0 && s_r[0].y == '0) begin
      prep_side_nxt = '{byp: 1'b1, mag: '0, dir: '0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int d = 0; d < D; d++) begin
        if (rdy[d]) begin
          v_r[d] <= (d == 0) ? up_valid : v_r[d-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s_r[0]    <= sum_nxt;
      side_r[0] <= up_side;
    end
    if (rdy[1]) begin
      s_r[1]    <= prep_nxt;
      side_r[1] <= prep_side_nxt;
    end
    for (int i = 0; i < N; i++) begin
      if (rdy[i+2]) begin
        s_r[i+2]    <= pva_pkg::vec_step(s_r[i+1], i);
        side_r[i+2] <= side_r[i+1];
      end
    end
  end

  assign up_ready = rdy[0];
  assign dn_valid = v_r[D-1];
  assign dn_v     = s_r[D-1];
  assign dn_side  = side_r[D-1];

endmodule

/* src/pva_scale.sv */
module pva_scale (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  pva_pkg::rot_t      up_v,
  input  pva_pkg::side_t     up_side,
  output logic               dn_valid,
  input  logic               dn_ready,
  output logic [16:0]        dn_mag,
  output logic signed [15:0] dn_dir
);

  localparam int D  = 3;
  localparam int HW = pva_pkg::XW / 2;
  localparam int PW = HW + pva_pkg::KW;
  localparam int SW = pva_pkg::XW + pva_pkg::KW;
  localparam int AQ = pva_pkg::AQW;

  logic [D-1:0] v_r;
  logic [D:0]   rdy;

  logic [PW-1:0]          lo_r, hi_r;
  logic signed [AQ-1:0]   aq_r;
  pva_pkg::side_t         side0_r, side1_r;
  logic [22:0]            mag1_r;
  logic signed [15:0]     dir1_r;
  logic [16:0]            mag_r;
  logic signed [15:0]     dir_r;

  logic [pva_pkg::XW-1:0] ux;
  pva_pkg::ang_t          zr;
  logic [SW-1:0]          prod;
  logic signed [15:0]     dir_sat;

  always_comb begin
    rdy[D] = dn_ready;
    for (int d = D - 1; d >= 0; d--) begin
      rdy[d] = !v_r[d] || rdy[d+1];
    end
  end

  always_comb begin
    ux   = (up_v.x > 0) ? up_v.x : '0;
    zr   = up_v.z + pva_pkg::ang_t'(1 << (pva_pkg::ANG_SHIFT - 1));
    prod = {hi_r, {HW{1'b0}}} + SW'(lo_r) + (SW'(1) << 43);
    if (aq_r > pva_pkg::PI_Q13) begin
      dir_sat = 16'(pva_pkg::PI_Q13);
    end else if (aq_r < -pva_pkg::PI_Q13) begin
      dir_sat = 16'(-pva_pkg::PI_Q13);
    end else begin
      dir_sat = aq_r[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int d = 0; d < D; d++) begin
        if (rdy[d]) begin
          v_r[d] <= (d == 0) ? up_valid : v_r[d-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      lo_r    <= PW'(ux[HW-1:0] * pva_pkg::GAIN_K);
      hi_r    <= PW'(ux[pva_pkg::XW-1:HW] * pva_pkg::GAIN_K);
      aq_r    <= AQ'(zr >>> pva_pkg::ANG_SHIFT);
      side0_r <= up_side;
    end
    if (rdy[1]) begin
      mag1_r  <= prod[SW-1:44];
      dir1_r  <= dir_sat;
      side1_r <= side0_r;
    end
    if (rdy[2]) begin
      if (side1_r.byp) begin
        mag_r <= side1_r.mag;
        dir_r <= side1_r.dir;
      end else begin
        mag_r <= (mag1_r > pva_pkg::MAG_MAX) ? pva_pkg::MAG_MAX[16:0] : mag1_r[16:0];
        dir_r <= dir1_r;
      end
    end
  end

  assign up_ready = rdy[0];
  assign dn_valid = v_r[D-1];
  assign dn_mag   = mag_r;
  assign dn_dir   = dir_r;

endmodule

/* src/polar_vector_adder_top.sv */
// Channel   Dir  Payload                                          Beat when
// in_chan   in   a_magnitude, a_direction, b_magnitude, b_direction valid && ready
// out_chan  out  sum_magnitude, sum_direction                    valid && ready
//
// One beat may enter every cycle while in_chan.ready is high; there is one register
// per rotation and per vectoring iteration.
// rst_n is synchronous, active low, and clears only the valid bits.
// Each stage holds while full and its successor holds, so bubbles close up and
// in_chan.ready stays high until every stage is full behind a stalled output.
module polar_vector_adder_top (
  input  logic      clk,
  input  logic      rst_n,
  pva_in_if.sink    in_chan,
  pva_out_if.source out_chan
);

  logic           rot_valid, rot_ready;
  pva_pkg::rot_t  rot_a, rot_b;
  pva_pkg::side_t rot_side;

  logic           vec_valid, vec_ready;
  pva_pkg::rot_t  vec_v;
  pva_pkg::side_t vec_side;

  // polar to components for both vectors side by side
  pva_rotate u_rotate (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_chan.valid),
    .up_ready (in_chan.ready),
    .a_mag    (in_chan.a_magnitude),
    .a_dir    (in_chan.a_direction),
    .b_mag    (in_chan.b_magnitude),
    .b_dir    (in_chan.b_direction),
    .dn_valid (rot_valid),
    .dn_ready (rot_ready),
    .dn_a     (rot_a),
    .dn_b     (rot_b),
    .dn_side  (rot_side)
  );

  // add components, then recover length and atan2 angle
  pva_vector u_vector (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (rot_valid),
    .up_ready (rot_ready),
    .up_a     (rot_a),
    .up_b     (rot_b),
    .up_side  (rot_side),
    .dn_valid (vec_valid),
    .dn_ready (vec_ready),
    .dn_v     (vec_v),
    .dn_side  (vec_side)
  );

  // remove gain, round, saturate, and pick the bypass result
  pva_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (vec_valid),
    .up_ready (vec_ready),
    .up_v     (vec_v),
    .up_side  (vec_side),
    .dn_valid (out_chan.valid),
    .dn_ready (out_chan.ready),
    .dn_mag   (out_chan.sum_magnitude),
    .dn_dir   (out_chan.sum_direction)
  );

`ifndef SYNTHESIS
  // input stalls only behind a full pipe and a stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (out_chan.valid && !out_chan.ready))
    else $error("input stalled without a stalled output");

  a_ready_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.ready |-> in_chan.ready)
    else $error("input stalled while output ready");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_chan.valid)
    else $error("output valid right after reset");
`endif

endmodule
